>>> src/cwb_pkg.sv
// cwb_pkg: shared types and fixed constants of the coalescing write buffer
// used by cwb_ctrl, cwb_datapath and coalescing_write_buffer; no dependencies
package cwb_pkg;

    localparam int DEPTH             = 8;
    localparam int ADDR_BITS         = 24;
    localparam int BLOCK_OFFSET_BITS = 4;
    localparam int PAGE_OFFSET_BITS  = 12;
    localparam int BLOCK_BITS        = ADDR_BITS - BLOCK_OFFSET_BITS;
    localparam int FRAME_BITS        = ADDR_BITS - PAGE_OFFSET_BITS;
    localparam int FRAME_LSB         = PAGE_OFFSET_BITS - BLOCK_OFFSET_BITS;
    localparam int IDX_W             = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W             = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_ENQUEUE     = 2'd0,
        KIND_DRAIN       = 2'd1,
        KIND_PROBE_BLOCK = 2'd2,
        KIND_PROBE_FRAME = 2'd3
    } kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_HOLD = 1'b1
    } state_t;

    typedef struct packed {
        logic exec;
    } cmd_t;

endpackage

>>> src/cwb_ctrl.sv
// cwb_ctrl: handshake controller of the coalescing write buffer
// depends on cwb_pkg for the state and command types
module cwb_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output cwb_pkg::cmd_t cmd
);

    cwb_pkg::state_t state_reg;
    cwb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cwb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cwb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cwb_pkg::ST_HOLD;
                end
            end
            cwb_pkg::ST_HOLD:
            begin
                if (out_ready && !in_valid)
                begin
                    state_next = cwb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cwb_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            cwb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            cwb_pkg::ST_HOLD:
            begin
                out_valid = 1'b1;
                in_ready  = out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        cmd.exec = in_valid && in_ready;
    end

endmodule

>>> src/cwb_datapath.sv
// cwb_datapath: entry store, parallel block and frame compare, result registers
// depends on cwb_pkg for constants, kind codes and the command struct
module cwb_datapath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  cwb_pkg::cmd_t                      cmd,
    input  logic [1:0]                         kind,
    input  logic [cwb_pkg::ADDR_BITS-1:0]      phys_addr,
    input  logic [cwb_pkg::FRAME_BITS-1:0]     page_frame,
    output logic                               success,
    output logic                               merged,
    output logic                               found,
    output logic [cwb_pkg::IDX_W-1:0]          hit_index,
    output logic [cwb_pkg::BLOCK_BITS-1:0]     drained_block,
    output logic [cwb_pkg::CNT_W-1:0]          occupancy
);

    localparam int DEPTH = cwb_pkg::DEPTH;
    localparam int BB    = cwb_pkg::BLOCK_BITS;
    localparam int IW    = cwb_pkg::IDX_W;
    localparam int CW    = cwb_pkg::CNT_W;

    logic [BB-1:0]    store_reg [DEPTH];
    logic [BB-1:0]    store_next [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    logic             success_reg, success_next;
    logic             merged_reg, merged_next;
    logic             found_reg, found_next;
    logic [IW-1:0]    hit_index_reg, hit_index_next;
    logic [BB-1:0]    drained_reg, drained_next;
    logic [CW-1:0]    occ_reg;

    logic [BB-1:0]    blk;
    logic             blk_hit;
    logic [IW-1:0]    blk_idx;
    logic             frm_hit;
    logic [IW-1:0]    frm_idx;

    // parallel compare, newest block match and oldest frame match
    always_comb
    begin
        blk     = phys_addr[cwb_pkg::ADDR_BITS-1:cwb_pkg::BLOCK_OFFSET_BITS];
        blk_hit = 1'b0;
        blk_idx = '0;
        frm_hit = 1'b0;
        frm_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (valid_reg[i] && store_reg[i] == blk)
            begin
                blk_hit = 1'b1;
                blk_idx = IW'(i);
            end
        end
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && store_reg[i][BB-1:cwb_pkg::FRAME_LSB] == page_frame)
            begin
                frm_hit = 1'b1;
                frm_idx = IW'(i);
            end
        end
    end

    always_comb
    begin
        store_next     = store_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        success_next   = 1'b0;
        merged_next    = 1'b0;
        found_next     = 1'b0;
        hit_index_next = '0;
        drained_next   = '0;
        unique case (cwb_pkg::kind_t'(kind))
            cwb_pkg::KIND_ENQUEUE:
            begin
                if (blk_hit)
                begin
                    success_next = 1'b1;
                    merged_next  = 1'b1;
                end
                else if (count_reg < CW'(DEPTH))
                begin
                    store_next[count_reg[IW-1:0]] = blk;
                    valid_next[count_reg[IW-1:0]] = 1'b1;
                    count_next                    = count_reg + CW'(1);
                    success_next                  = 1'b1;
                end
            end
            cwb_pkg::KIND_DRAIN:
            begin
                if (count_reg != '0)
                begin
                    drained_next = store_reg[0];
                    for (int i = 0; i < DEPTH - 1; i++)
                    begin
                        store_next[i] = store_reg[i+1];
                    end
                    store_next[DEPTH-1] = '0;
                    valid_next          = valid_reg >> 1;
                    count_next          = count_reg - CW'(1);
                    success_next        = 1'b1;
                end
            end
            cwb_pkg::KIND_PROBE_BLOCK:
            begin
                found_next     = blk_hit;
                hit_index_next = blk_idx;
            end
            cwb_pkg::KIND_PROBE_FRAME:
            begin
                found_next     = frm_hit;
                hit_index_next = frm_idx;
            end
            default:
            begin
                found_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    // entry payload and result word
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            store_reg     <= store_next;
            success_reg   <= success_next;
            merged_reg    <= merged_next;
            found_reg     <= found_next;
            hit_index_reg <= hit_index_next;
            drained_reg   <= drained_next;
            occ_reg       <= count_next;
        end
    end

    assign success       = success_reg;
    assign merged        = merged_reg;
    assign found         = found_reg;
    assign hit_index     = hit_index_reg;
    assign drained_block = drained_reg;
    assign occupancy     = occ_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("valid flags disagree with entry count");

    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> valid_reg[0])
        else $error("head slot empty with entries queued");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(cmd.exec) && found_reg) |-> (CW'(hit_index_reg) < occ_reg))
        else $error("probe hit beyond occupancy");

endmodule

>>> src/coalescing_write_buffer.sv
// coalescing_write_buffer: ordered write buffer of block addresses with merge
// result: registered, valid in the cycle after the input word is taken
// throughput: one word per cycle while the result side takes each result;
// the entry compare is a combinational parallel match over all slots
// reset: asynchronous, empties the buffer and drops any pending result
// depends on cwb_pkg, cwb_ctrl and cwb_datapath
module coalescing_write_buffer
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          kind,
    input  logic [cwb_pkg::ADDR_BITS-1:0]       phys_addr,
    input  logic [cwb_pkg::FRAME_BITS-1:0]      page_frame,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                success,
    output logic                                merged,
    output logic                                found,
    output logic [cwb_pkg::IDX_W-1:0]           hit_index,
    output logic [cwb_pkg::BLOCK_BITS-1:0]      drained_block,
    output logic [cwb_pkg::CNT_W-1:0]           occupancy
);

    cwb_pkg::cmd_t cmd;

    cwb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    cwb_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .kind          (kind),
        .phys_addr     (phys_addr),
        .page_frame    (page_frame),
        .success       (success),
        .merged        (merged),
        .found         (found),
        .hit_index     (hit_index),
        .drained_block (drained_block),
        .occupancy     (occupancy)
    );

endmodule
